// ===== hw/rtl/ntl_pkg.sv =====
// ----------------------------------------------------------------------------
// ntl_pkg
// Shared widths, codes and record types of the neighbor latency average table.
// ----------------------------------------------------------------------------
package ntl_pkg;

   localparam int ADDR_W      = 16;
   localparam int TS_W        = 32;
   localparam int SAMPLE_W    = 32;
   localparam int SUM_W       = 48;
   localparam int COUNT_W     = 16;
   localparam int INDEX_W     = 4;
   localparam int STATUS_W    = 2;
   localparam int DIFF_W      = TS_W + 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COUNT_W-1:0]         COUNT_MAX  = '1;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   typedef enum logic [STATUS_W-1:0] {
      STATUS_UPDATED = 2'd0,
      STATUS_ADDED   = 2'd1,
      STATUS_DROPPED = 2'd2
   } status_type;

   // one acknowledgement after the delay has been worked out
   typedef struct packed {
      logic [ADDR_W-1:0]          addr;
      logic signed [SAMPLE_W-1:0] sample;
   } item_type;

   // one table row as held in the data memory
   typedef struct packed {
      logic signed [SUM_W-1:0]    sum;
      logic [COUNT_W-1:0]         count;
      logic signed [SAMPLE_W-1:0] average;
   } entry_type;

   typedef struct packed {
      status_type                 status;
      logic [INDEX_W-1:0]         entry_index;
      logic signed [SAMPLE_W-1:0] sample_latency;
      logic signed [SAMPLE_W-1:0] average_latency;
      logic [COUNT_W-1:0]         sample_count;
   } result_type;

endpackage

// ===== hw/rtl/ntl_ram.sv =====
// ----------------------------------------------------------------------------
// ntl_ram
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module ntl_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ntl_front.sv =====
// ----------------------------------------------------------------------------
// ntl_front
// Accept acknowledgements and form the halved, saturated one-way delay.
// ----------------------------------------------------------------------------
module ntl_front import ntl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [ADDR_W-1:0] req_sender_addr,
   input  logic [TS_W-1:0]   req_t1_local_send,
   input  logic [TS_W-1:0]   req_t2_remote_arrival,
   input  logic [TS_W-1:0]   req_t3_remote_send,
   input  logic [TS_W-1:0]   req_t4_local_arrival,
   output logic              push_valid,
   output item_type          push_item,
   input  logic              push_stall
);

   logic                     a_valid_ff, a_valid_in;
   logic [ADDR_W-1:0]        a_addr_ff;
   logic signed [TS_W:0]     a_rt_ff, a_rt_in;
   logic signed [TS_W:0]     a_ta_ff, a_ta_in;
   logic                     b_valid_ff, b_valid_in;
   logic [ADDR_W-1:0]        b_addr_ff;
   logic signed [DIFF_W-1:0] b_diff_ff, b_diff_in;
   logic                     a_stall, b_stall;
   logic signed [DIFF_W-1:0] diff_rnd, half;
   logic [DIFF_W-SAMPLE_W:0] half_hi;
   logic signed [SAMPLE_W-1:0] sample;

   assign b_stall   = b_valid_ff & push_stall;
   assign a_stall   = a_valid_ff & b_stall;
   assign req_stall = a_stall;

   // round trip and remote turnaround, exact in one extra bit
   assign a_rt_in = $signed({1'b0, req_t4_local_arrival}) - $signed({1'b0, req_t1_local_send});
   assign a_ta_in = $signed({1'b0, req_t3_remote_send}) - $signed({1'b0, req_t2_remote_arrival});
   assign b_diff_in = DIFF_W'(a_rt_ff) - DIFF_W'(a_ta_ff);

   assign a_valid_in = a_stall ? a_valid_ff : req_valid;
   assign b_valid_in = b_stall ? b_valid_ff : a_valid_ff;

   // halve toward zero: add one to negative values before the shift
   assign diff_rnd = b_diff_ff + DIFF_W'(b_diff_ff[DIFF_W-1]);
   assign half     = diff_rnd >>> 1;
   assign half_hi  = half[DIFF_W-1:SAMPLE_W-1];

   always_comb begin
      if ((half_hi == '0) || (half_hi == '1)) begin
         sample = half[SAMPLE_W-1:0];
      end else if (half[DIFF_W-1]) begin
         sample = SAMPLE_MIN;
      end else begin
         sample = SAMPLE_MAX;
      end
   end

   assign push_valid       = b_valid_ff;
   assign push_item.addr   = b_addr_ff;
   assign push_item.sample = sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!a_stall) begin
         a_addr_ff <= req_sender_addr;
         a_rt_ff   <= a_rt_in;
         a_ta_ff   <= a_ta_in;
      end
      if (!b_stall) begin
         b_addr_ff <= a_addr_ff;
         b_diff_ff <= b_diff_in;
      end
   end

endmodule

// ===== hw/rtl/ntl_queue.sv =====
// ----------------------------------------------------------------------------
// ntl_queue
// Short queue between the delay front end and the table back end.
// ----------------------------------------------------------------------------
module ntl_queue import ntl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_stall,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_stall,
   output item_type pop_item
);

   item_type          q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign push_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = q_ff[rd_ptr_ff];

   assign do_push = push_valid & ~push_stall;
   assign do_pop  = pop_valid & ~pop_stall;

   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hw/rtl/ntl_back.sv =====
// ----------------------------------------------------------------------------
// ntl_back
// Table search, append, accumulate and serial averaging divide.
// ----------------------------------------------------------------------------
module ntl_back import ntl_pkg::*; #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       pop_valid,
   output logic       pop_stall,
   input  item_type   pop_item,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_result
);

   localparam int AW     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW     = $clog2(TABLE_ENTRIES + 1);
   localparam int STEP_W = $clog2(SUM_W);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SCAN   = 7'b0000010,
      ST_FETCH  = 7'b0000100,
      ST_PREP   = 7'b0001000,
      ST_DIVIDE = 7'b0010000,
      ST_FINISH = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type                  state_ff, state_in;
   item_type                   cur_ff, cur_in;
   logic [CW-1:0]              scan_ptr_ff, scan_ptr_in;
   logic [CW-1:0]              used_ff, used_in;
   logic                       chk_valid_ff, chk_valid_in;
   logic [AW-1:0]              chk_idx_ff, chk_idx_in;
   logic [AW-1:0]              slot_ff, slot_in;
   status_type                 status_ff, status_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic signed [SAMPLE_W-1:0] res_avg_ff, res_avg_in;
   logic                       write_ff, write_in;
   logic                       neg_ff, neg_in;
   logic [SUM_W-1:0]           quot_ff, quot_in;
   logic [COUNT_W-1:0]         rem_ff, rem_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   result_type                 rsp_ff, rsp_in;

   logic                       addr_wr_en;
   logic [ADDR_W-1:0]          addr_rd_data;
   logic                       data_wr_en;
   entry_type                  data_wr_data, data_rd_data;
   logic                       match;
   logic [COUNT_W:0]           rem_shift;
   logic [COUNT_W+1:0]         trial;
   logic                       trial_ge;

   ntl_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_ENTRIES)) u_addr_ram (
      .clock   (clock),
      .wr_en   (addr_wr_en),
      .wr_addr (used_ff[AW-1:0]),
      .wr_data (cur_ff.addr),
      .rd_addr (scan_ptr_ff[AW-1:0]),
      .rd_data (addr_rd_data)
   );

   ntl_ram #(.WIDTH($bits(entry_type)), .DEPTH(TABLE_ENTRIES)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_wr_en),
      .wr_addr (slot_ff),
      .wr_data (data_wr_data),
      .rd_addr (chk_idx_ff),
      .rd_data (data_rd_data)
   );

   assign pop_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   assign match = chk_valid_ff && (addr_rd_data == cur_ff.addr);

   assign data_wr_data.sum     = sum_ff;
   assign data_wr_data.count   = count_ff;
   assign data_wr_data.average = res_avg_ff;

   // one restoring divide step on the magnitude of the sum
   assign rem_shift = {rem_ff, quot_ff[SUM_W-1]};
   assign trial     = {1'b0, rem_shift} - {2'b00, count_ff};
   assign trial_ge  = ~trial[COUNT_W+1];

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      scan_ptr_in  = scan_ptr_ff;
      used_in      = used_ff;
      chk_valid_in = chk_valid_ff;
      chk_idx_in   = chk_idx_ff;
      slot_in      = slot_ff;
      status_in    = status_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      res_avg_in   = res_avg_ff;
      write_in     = write_ff;
      neg_in       = neg_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;
      addr_wr_en   = 1'b0;
      data_wr_en   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               cur_in       = pop_item;
               scan_ptr_in  = '0;
               chk_valid_in = 1'b0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (match) begin
               chk_valid_in = 1'b0;
               slot_in      = chk_idx_ff;
               status_in    = STATUS_UPDATED;
               state_in     = ST_FETCH;
            end else if (scan_ptr_ff < used_ff) begin
               chk_valid_in = 1'b1;
               chk_idx_in   = scan_ptr_ff[AW-1:0];
               scan_ptr_in  = scan_ptr_ff + 1'b1;
            end else if (chk_valid_ff) begin
               chk_valid_in = 1'b0;
            end else if (used_ff < CW'(TABLE_ENTRIES)) begin
               // append the sender, sum starts from this sample
               addr_wr_en = 1'b1;
               slot_in    = used_ff[AW-1:0];
               used_in    = used_ff + 1'b1;
               status_in  = STATUS_ADDED;
               sum_in     = SUM_W'(cur_ff.sample);
               count_in   = COUNT_W'(1);
               write_in   = 1'b1;
               state_in   = ST_PREP;
            end else begin
               slot_in    = '0;
               status_in  = STATUS_DROPPED;
               res_avg_in = '0;
               count_in   = '0;
               write_in   = 1'b0;
               state_in   = ST_DONE;
            end
         end
         ST_FETCH: begin
            if (data_rd_data.count == COUNT_MAX) begin
               // saturated: hold sum, count and average
               res_avg_in = data_rd_data.average;
               count_in   = data_rd_data.count;
               write_in   = 1'b0;
               state_in   = ST_DONE;
            end else begin
               sum_in   = data_rd_data.sum + SUM_W'(cur_ff.sample);
               count_in = data_rd_data.count + 1'b1;
               write_in = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            neg_in   = sum_ff[SUM_W-1];
            quot_in  = sum_ff[SUM_W-1] ? -sum_ff : sum_ff;
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            rem_in  = trial_ge ? trial[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
            quot_in = {quot_ff[SUM_W-2:0], trial_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            res_avg_in = neg_ff ? -quot_ff[SAMPLE_W-1:0] : quot_ff[SAMPLE_W-1:0];
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               data_wr_en             = write_ff;
               rsp_valid_in           = 1'b1;
               rsp_in.status          = status_ff;
               rsp_in.entry_index     = INDEX_W'(slot_ff);
               rsp_in.sample_latency  = cur_ff.sample;
               rsp_in.average_latency = res_avg_ff;
               rsp_in.sample_count    = count_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      scan_ptr_ff <= scan_ptr_in;
      chk_idx_ff  <= chk_idx_in;
      slot_ff     <= slot_in;
      status_ff   <= status_in;
      sum_ff      <= sum_in;
      count_ff    <= count_in;
      res_avg_ff  <= res_avg_in;
      write_ff    <= write_in;
      neg_ff      <= neg_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      rsp_ff      <= rsp_in;
   end

endmodule

// ===== hw/rtl/neighbor_latency_average_table.sv =====
// ----------------------------------------------------------------------------
// neighbor_latency_average_table
// Per-neighbor running average of the two-way time transfer one-way delay.
// ----------------------------------------------------------------------------
// Path: a request passes the front end registers and the queue, then the back end
//   searches the table entries in use; a saturated hit or a drop skips the divide.
// Flow: the table back end takes a new acknowledgement only once it is idle; the
//   two-entry queue lets the delay front end run ahead by up to four items.
// Reset: synchronous, active high; empties the table (fill count to zero),
//   the queue and the result register. Table memories are not cleared.
module neighbor_latency_average_table import ntl_pkg::*; #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [ADDR_W-1:0]          req_sender_addr,
   input  logic [TS_W-1:0]            req_t1_local_send,
   input  logic [TS_W-1:0]            req_t2_remote_arrival,
   input  logic [TS_W-1:0]            req_t3_remote_send,
   input  logic [TS_W-1:0]            req_t4_local_arrival,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [INDEX_W-1:0]         rsp_entry_index,
   output logic signed [SAMPLE_W-1:0] rsp_sample_latency,
   output logic signed [SAMPLE_W-1:0] rsp_average_latency,
   output logic [COUNT_W-1:0]         rsp_sample_count
);

   // front end to queue
   logic       push_valid;
   logic       push_stall;
   item_type   push_item;
   // queue to back end
   logic       pop_valid;
   logic       pop_stall;
   item_type   pop_item;
   // back end result register
   result_type rsp_result;

   // Front end: take one transfer per cycle while not stalled, form the round trip and the
   // remote turnaround, then halve the difference and saturate it.
   ntl_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_sender_addr       (req_sender_addr),
      .req_t1_local_send     (req_t1_local_send),
      .req_t2_remote_arrival (req_t2_remote_arrival),
      .req_t3_remote_send    (req_t3_remote_send),
      .req_t4_local_arrival  (req_t4_local_arrival),
      .push_valid            (push_valid),
      .push_item             (push_item),
      .push_stall            (push_stall)
   );

   // Decouple: hold finished delays while the back end is busy with a search or a divide.
   ntl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_stall  (pop_stall),
      .pop_item   (pop_item)
   );

   // Back end: search the address memory, append or drop on a miss,
   // accumulate, divide serially and present the result in its own register.
   ntl_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_stall  (pop_stall),
      .pop_item   (pop_item),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   // unpack the result record onto its ports
   assign rsp_status          = rsp_result.status;
   assign rsp_entry_index     = rsp_result.entry_index;
   assign rsp_sample_latency  = rsp_result.sample_latency;
   assign rsp_average_latency = rsp_result.average_latency;
   assign rsp_sample_count    = rsp_result.sample_count;

   // a dropped acknowledgement reports no slot, average or count
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_DROPPED) |->
         (rsp_sample_count == '0) && (rsp_entry_index == '0) && (rsp_average_latency == '0))
      else $error("dropped result carries table data");

   // a freshly appended neighbor holds exactly this one sample
   a_added_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_ADDED) |->
         (rsp_sample_count == COUNT_W'(1)) && (rsp_average_latency == rsp_sample_latency))
      else $error("new entry does not hold its first sample alone");

   // an updated neighbor always has at least one sample
   a_updated_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_UPDATED) |-> (rsp_sample_count != '0))
      else $error("updated entry reports an empty count");

endmodule

// ===== verif/neighbor_latency_average_table_tb.sv =====
// ----------------------------------------------------------------------------
// neighbor_latency_average_table_tb
// Self-checking bench for the neighbor latency table: drives acknowledgements
// with random idling on both channels, predicts every result transfer from a
// behavioral copy of the table, and compares each result field by field.
// ----------------------------------------------------------------------------
module neighbor_latency_average_table_tb;

   import ntl_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 2_000_000;
   localparam int          DRAIN_CYCLES = 100;
   localparam int          MAX_REPORTS  = 200;

   // -------------------------------------------------------------------------
   // Latency table tracker: holds the expected table contents and the queue of
   // results still owed by the block.
   // -------------------------------------------------------------------------
   class latency_scoreboard;
      localparam int SLOTS = 16;

      logic [ADDR_W-1:0] slot_addr[SLOTS];
      longint            slot_sum[SLOTS];
      int unsigned       slot_count[SLOTS];
      int                slot_average[SLOTS];
      logic [TS_W-1:0]   slot_last_seen[SLOTS];
      int                used;
      result_type        owed_results[$];
      int                errors;

      function new();
         used   = 0;
         errors = 0;
      endfunction

      // Work out the result of one accepted acknowledgement and queue it.
      function void note_request(logic [ADDR_W-1:0] addr, logic [TS_W-1:0] t1,
                                 logic [TS_W-1:0] t2, logic [TS_W-1:0] t3,
                                 logic [TS_W-1:0] t4);
         longint     half;
         int         slot;
         bit         found;
         result_type want;
         // form the differences exactly, halve toward zero, then clamp
         half = (($signed({32'd0, t4}) - $signed({32'd0, t1})) -
                 ($signed({32'd0, t3}) - $signed({32'd0, t2}))) / 2;
         if (half > longint'(SAMPLE_MAX)) half = longint'(SAMPLE_MAX);
         if (half < longint'(SAMPLE_MIN)) half = longint'(SAMPLE_MIN);
         want.sample_latency = half[SAMPLE_W-1:0];
         found = 1'b0;
         slot  = 0;
         for (int i = 0; i < used; i++) begin
            if (!found && slot_addr[i] == addr) begin
               found = 1'b1;
               slot  = i;
            end
         end
         if (found) begin
            want.status = STATUS_UPDATED;
         end else if (used < SLOTS) begin
            slot               = used;
            slot_addr[slot]    = addr;
            slot_sum[slot]     = 0;
            slot_count[slot]   = 0;
            slot_average[slot] = 0;
            used++;
            want.status = STATUS_ADDED;
         end else begin
            // table full: drop, but the delay still goes out
            want.status          = STATUS_DROPPED;
            want.entry_index     = '0;
            want.average_latency = '0;
            want.sample_count    = '0;
            owed_results.push_back(want);
            return;
         end
         slot_last_seen[slot] = t4;
         // a saturated count freezes sum and average
         if (slot_count[slot] < COUNT_MAX) begin
            slot_sum[slot]     += half;
            slot_count[slot]   += 1;
            slot_average[slot] = int'(slot_sum[slot] / longint'(slot_count[slot]));
         end
         want.entry_index     = slot[INDEX_W-1:0];
         want.average_latency = slot_average[slot];
         want.sample_count    = slot_count[slot][COUNT_W-1:0];
         owed_results.push_back(want);
      endfunction

      function void report_field(string name, longint want, longint got);
         if (want != got) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: %s mismatch, expected %0d, actual %0d",
                        $time, name, want, got);
         end
      endfunction

      // Compare one result transfer with the oldest owed result.
      function void check_result(result_type got);
         result_type want;
         if (owed_results.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: result with none expected, expected none, actual %p",
                        $time, got);
            return;
         end
         want = owed_results.pop_front();
         report_field("status", want.status, got.status);
         report_field("entry_index", want.entry_index, got.entry_index);
         report_field("sample_latency", want.sample_latency, got.sample_latency);
         report_field("average_latency", want.average_latency, got.average_latency);
         report_field("sample_count", want.sample_count, got.sample_count);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block inputs; every input starts at a known value.
   // -------------------------------------------------------------------------
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [ADDR_W-1:0]          req_sender_addr = '0;
   logic [TS_W-1:0]            req_t1_local_send = '0;
   logic [TS_W-1:0]            req_t2_remote_arrival = '0;
   logic [TS_W-1:0]            req_t3_remote_send = '0;
   logic [TS_W-1:0]            req_t4_local_arrival = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic [INDEX_W-1:0]         rsp_entry_index;
   logic signed [SAMPLE_W-1:0] rsp_sample_latency;
   logic signed [SAMPLE_W-1:0] rsp_average_latency;
   logic [COUNT_W-1:0]         rsp_sample_count;

   int          req_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int unsigned cycle_count = 0;

   latency_scoreboard sb = new();

   always #5 clock = ~clock;

   neighbor_latency_average_table u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_sender_addr       (req_sender_addr),
      .req_t1_local_send     (req_t1_local_send),
      .req_t2_remote_arrival (req_t2_remote_arrival),
      .req_t3_remote_send    (req_t3_remote_send),
      .req_t4_local_arrival  (req_t4_local_arrival),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_entry_index       (rsp_entry_index),
      .rsp_sample_latency    (rsp_sample_latency),
      .rsp_average_latency   (rsp_average_latency),
      .rsp_sample_count      (rsp_sample_count)
   );

   // Stall the result channel at random, at the rate the current phase sets.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Watch both channels; a transfer happens where valid is high and stall low.
   always @(posedge clock) begin
      result_type got;
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_sender_addr, req_t1_local_send, req_t2_remote_arrival,
                            req_t3_remote_send, req_t4_local_arrival);
         if (rsp_valid && !rsp_stall) begin
            got.status          = status_type'(rsp_status);
            got.entry_index     = rsp_entry_index;
            got.sample_latency  = rsp_sample_latency;
            got.average_latency = rsp_average_latency;
            got.sample_count    = rsp_sample_count;
            sb.check_result(got);
         end
      end
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Present one acknowledgement and hold it until the block takes it.
   // Idle cycles go in front at the current sender rate; valid stays high
   // straight into the next item when no idle cycle is drawn.
   task automatic send_ack(input logic [ADDR_W-1:0] addr, input logic [TS_W-1:0] t1,
                           input logic [TS_W-1:0] t2, input logic [TS_W-1:0] t3,
                           input logic [TS_W-1:0] t4);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_sender_addr       <= addr;
      req_t1_local_send     <= t1;
      req_t2_remote_arrival <= t2;
      req_t3_remote_send    <= t3;
      req_t4_local_arrival  <= t4;
      req_valid             <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Draw four timestamps. Most look like a real exchange: a remote clock
   // offset, a path delay and a turnaround, wrapping as 32-bit counters do.
   // The rest are raw noise or rail values that drive the clamp.
   task automatic make_stamps(output logic [TS_W-1:0] t1, output logic [TS_W-1:0] t2,
                              output logic [TS_W-1:0] t3, output logic [TS_W-1:0] t4);
      int unsigned pick;
      int unsigned path;
      int unsigned turn;
      pick = $urandom_range(99);
      if (pick < 15) begin
         t1 = $urandom;
         t2 = $urandom;
         t3 = $urandom;
         t4 = $urandom;
      end else if (pick < 20) begin
         t1 = $urandom_range(1) ? '1 : '0;
         t2 = $urandom_range(1) ? '1 : '0;
         t3 = $urandom_range(1) ? '1 : '0;
         t4 = $urandom_range(1) ? '1 : '0;
      end else begin
         path = $urandom_range(200_000);
         turn = $urandom_range(5_000_000);
         t1   = $urandom;
         t2   = t1 + path + $urandom;
         t3   = t2 + turn;
         t4   = t1 + 2 * path + turn + $urandom_range(7);
      end
   endtask

   // Pick a sender: mostly a neighbor already in the table, else any address.
   task automatic send_random_ack();
      logic [ADDR_W-1:0] addr;
      logic [TS_W-1:0]   t1, t2, t3, t4;
      if (sb.used > 0 && $urandom_range(99) < 75)
         addr = sb.slot_addr[$urandom_range(sb.used - 1)];
      else
         addr = ADDR_W'($urandom_range(16'hFFFF));
      make_stamps(t1, t2, t3, t4);
      send_ack(addr, t1, t2, t3, t4);
   endtask

   initial begin
      logic [TS_W-1:0] t1, t2, t3, t4;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: rail addresses, clamp at both ends, halving toward zero
      // for odd deltas of either sign, then fill the table and drop.
      send_ack(16'h0000, '0, '0, '0, '0);
      send_ack(16'hFFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
      send_ack(16'h0000, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
      send_ack(16'hFFFF, 32'd3, '0, '0, '0);
      send_ack(16'hFFFF, '0, '0, '0, 32'd3);
      send_ack(16'h0000, 32'd1, '0, '0, '0);
      send_ack(16'hAAAA, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
      send_ack(16'h5555, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
      for (int i = 0; i < 12; i++) begin
         make_stamps(t1, t2, t3, t4);
         send_ack(ADDR_W'(16'h1000 + i), t1, t2, t3, t4);
      end
      send_ack(16'h1234, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
      send_ack(16'h4321, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
      send_ack(16'hAAAA, 32'd100, 32'd5000, 32'd5010, 32'd141);

      // Random, result channel mostly stalled first, then sender mostly idle.
      req_idle_pct  = 38;
      rsp_stall_pct = 88;
      repeat (640) send_random_ack();
      req_idle_pct  = 88;
      rsp_stall_pct = 38;
      repeat (640) send_random_ack();

      // Full speed from here. Hit the first neighbor back to back a few
      // times, then random traffic.
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      repeat (6) begin
         make_stamps(t1, t2, t3, t4);
         send_ack(sb.slot_addr[0], t1, t2, t3, t4);
      end
      repeat (620) send_random_ack();
      req_valid <= 1'b0;

      // Drain: wait for every owed result, then watch for strays.
      while (sb.owed_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.owed_results.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
